@@ hdl/bitmap_next_fit_block_allocator_assert.svh @@
// assertion macros for the bitmap next-fit block allocator
// expects clk and rst_n in the scope of use
`ifndef BITMAP_NEXT_FIT_BLOCK_ALLOCATOR_ASSERT_SVH
`define BITMAP_NEXT_FIT_BLOCK_ALLOCATOR_ASSERT_SVH

// property checked on every edge outside reset
`define BNFA_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define BNFA_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hdl/bnfa_pkg.sv @@
// shared types and constants of the bitmap next-fit block allocator
// no dependencies
package bnfa_pkg;

  localparam int WORD_BITS = 32;
  localparam int HINT_W    = 11;
  localparam int CNT_W     = 17;

  localparam logic [WORD_BITS-1:0] FULL_WORD = 32'hFFFF_FFFF;
  localparam logic [CNT_W-1:0]     COUNT_MAX = 17'h1_0000;
  localparam logic [CNT_W-1:0]     TOTAL_RST = 17'h1_0000;

  localparam logic [1:0] MODE_ALLOC = 2'd0;
  localparam logic [1:0] MODE_FREE  = 2'd1;
  localparam logic [1:0] MODE_LOAD  = 2'd2;

  localparam logic [1:0] STAT_OK      = 2'd0;
  localparam logic [1:0] STAT_NO_FREE = 2'd1;
  localparam logic [1:0] STAT_RANGE   = 2'd2;

  localparam logic [1:0] CFG_TOTAL     = 2'd0;
  localparam logic [1:0] CFG_START     = 2'd1;
  localparam logic [1:0] CFG_INIT_FREE = 2'd2;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] block_number;
    logic [10:0] word_index;
    logic [31:0] word_value;
  } in_beat_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] granted_block;
    logic [16:0] free_count;
  } out_beat_t;

  typedef struct packed {
    logic       hit;
    logic [4:0] bit_idx;
  } srch_res_t;

endpackage

@@ hdl/bnfa_map_ram.sv @@
// used-block bitmap storage, one write port and one registered read port
// depends on bnfa_pkg
module bnfa_map_ram #(
  parameter int DEPTH = 2048,
  parameter int AW    = 11
) (
  input  logic                           clk,
  input  logic                           we,
  input  logic [AW-1:0]                  waddr,
  input  logic [bnfa_pkg::WORD_BITS-1:0] wdata,
  input  logic [AW-1:0]                  raddr,
  output logic [bnfa_pkg::WORD_BITS-1:0] rdata
);
  import bnfa_pkg::*;

  logic [WORD_BITS-1:0] mem [DEPTH];
  logic [WORD_BITS-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

@@ hdl/bnfa_word_search.sv @@
// finds the lowest clear bit of one bitmap word inside the data range
// depends on bnfa_pkg
module bnfa_word_search (
  input  logic [bnfa_pkg::WORD_BITS-1:0] word,
  input  logic [bnfa_pkg::HINT_W-1:0]    idx,
  input  logic [15:0]                    range_lo,
  input  logic [bnfa_pkg::CNT_W-1:0]     eff_total,
  output bnfa_pkg::srch_res_t            res
);
  import bnfa_pkg::*;

  logic [WORD_BITS-1:0] lo_mask;
  logic [WORD_BITS-1:0] hi_mask;
  logic [WORD_BITS-1:0] cand;
  logic [WORD_BITS-1:0] lowest;
  logic [4:0]           bit_idx;
  logic [11:0]          last_word;

  assign last_word = eff_total[16:5];

  always_comb begin
    if (idx > range_lo[15:5]) begin
      lo_mask = FULL_WORD;
    end else if (idx == range_lo[15:5]) begin
      lo_mask = FULL_WORD << range_lo[4:0];
    end else begin
      lo_mask = '0;
    end
    if ({1'b0, idx} < last_word) begin
      hi_mask = FULL_WORD;
    end else if ({1'b0, idx} == last_word) begin
      hi_mask = ~(FULL_WORD << eff_total[4:0]);
    end else begin
      hi_mask = '0;
    end
  end

  assign cand   = ~word & lo_mask & hi_mask;
  assign lowest = cand & (~cand + 32'd1);

  always_comb begin
    bit_idx = '0;
    for (int i = 0; i < WORD_BITS; i++) begin
      if (lowest[i]) begin
        bit_idx = bit_idx | 5'(i);
      end
    end
  end

  assign res.hit     = |cand;
  assign res.bit_idx = bit_idx;

endmodule

@@ hdl/bitmap_next_fit_block_allocator.sv @@
// Next-fit block allocator over a used-block bitmap held in one synchronous RAM.
// Each beat produces one result. A load, an undefined mode and any item rejected
// up front (allocation with a zero counter or empty volume, free out of range) go
// straight from acceptance to the result state; a free passes through read, write
// back and result. An allocation examines bitmap words from the hint, then gives its
// result: the RAM read port delivers one word per cycle, so at most every bitmap word
// in use is examined. One item is in work at a
// time; the next beat is taken while the previous result waits in the output
// register, and a finished result that finds that register still full holds the
// input off until the result side takes its beat.
// Bitmap words must be loaded before they are scanned or freed; there is no
// clearing pass after reset.
// depends on bnfa_pkg, bnfa_map_ram, bnfa_word_search
module bitmap_next_fit_block_allocator #(
  parameter int MAP_WORDS = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  bnfa_pkg::in_beat_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output bnfa_pkg::out_beat_t out_data,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [16:0]         cfg_wdata
);
  import bnfa_pkg::*;

  `include "bitmap_next_fit_block_allocator_assert.svh"

  localparam int AW      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int CAP_RAW = MAP_WORDS * WORD_BITS;
  localparam logic [CNT_W-1:0] CAP = (CAP_RAW < 65536) ? CNT_W'(CAP_RAW) : COUNT_MAX;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_FREE = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [CNT_W-1:0] total_r;
  logic [15:0]      start_r;
  logic [CNT_W-1:0] init_r;

  logic [1:0]        state_r, state_nxt;
  logic [HINT_W-1:0] cur_r, cur_nxt;
  logic [11:0]       n_r, n_nxt;
  logic [15:0]       blk_r, blk_nxt;
  logic [HINT_W-1:0] hint_r, hint_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  out_beat_t         res_r, res_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_beat_t         out_data_r, out_data_nxt;

  logic [CNT_W-1:0]     eff_total;
  logic [11:0]          words;
  logic [HINT_W-1:0]    scan_start;
  logic [11:0]          cur_inc;
  logic [HINT_W-1:0]    cur_next_idx;
  logic                 in_fire;
  logic                 out_free;
  logic [CNT_W-1:0]     cnt_up;
  logic [CNT_W-1:0]     init_sat;

  logic                 mem_we;
  logic [AW-1:0]        mem_waddr;
  logic [WORD_BITS-1:0] mem_wdata;
  logic [AW-1:0]        mem_raddr;
  logic [WORD_BITS-1:0] mem_rdata;
  srch_res_t            srch;

  bnfa_map_ram #(
    .DEPTH (MAP_WORDS),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  bnfa_word_search u_search (
    .word      (mem_rdata),
    .idx       (cur_r),
    .range_lo  (start_r),
    .eff_total (eff_total),
    .res       (srch)
  );

  assign eff_total    = (total_r > CAP) ? CAP : total_r;
  assign words        = eff_total[16:5] + {11'd0, |eff_total[4:0]};
  assign scan_start   = ({1'b0, hint_r} < words) ? hint_r : '0;
  assign cur_inc      = {1'b0, cur_r} + 12'd1;
  assign cur_next_idx = (cur_inc >= words) ? '0 : cur_inc[HINT_W-1:0];
  assign in_ready     = (state_r == S_IDLE);
  assign in_fire      = in_valid && in_ready;
  assign out_free     = !out_valid_r || out_ready;
  assign cnt_up       = (cnt_r < COUNT_MAX) ? cnt_r + 17'd1 : cnt_r;
  assign init_sat     = (init_r > COUNT_MAX) ? COUNT_MAX : init_r;

  always_comb begin
    state_nxt     = state_r;
    cur_nxt       = cur_r;
    n_nxt         = n_r;
    blk_nxt       = blk_r;
    hint_nxt      = hint_r;
    cnt_nxt       = cnt_r;
    res_nxt       = res_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_data_nxt  = out_data_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(cur_r);
    mem_wdata     = mem_rdata;
    mem_raddr     = AW'(cur_r);

    case (state_r)
      S_IDLE: begin
        if (in_data.mode == MODE_ALLOC) begin
          mem_raddr = AW'(scan_start);
        end else begin
          mem_raddr = AW'(in_data.block_number[15:5]);
        end
        if (in_fire) begin
          res_nxt = '{status: STAT_OK, granted_block: 16'd0, free_count: cnt_r};
          state_nxt = S_DONE;
          case (in_data.mode)
            MODE_ALLOC: begin
              if (cnt_r == '0 || words == '0) begin
                res_nxt.status = STAT_NO_FREE;
              end else begin
                cur_nxt   = scan_start;
                n_nxt     = '0;
                state_nxt = S_SCAN;
              end
            end
            MODE_FREE: begin
              if (in_data.block_number < start_r ||
                  {1'b0, in_data.block_number} >= eff_total) begin
                res_nxt.status = STAT_RANGE;
              end else begin
                blk_nxt   = in_data.block_number;
                state_nxt = S_FREE;
              end
            end
            MODE_LOAD: begin
              if (32'(in_data.word_index) < MAP_WORDS) begin
                mem_we    = 1'b1;
                mem_waddr = AW'(in_data.word_index);
                mem_wdata = in_data.word_value;
              end
              cnt_nxt            = init_sat;
              hint_nxt           = start_r[15:5];
              res_nxt.free_count = init_sat;
            end
            default: begin
            end
          endcase
        end
      end
      S_SCAN: begin
        mem_raddr = AW'(cur_next_idx);
        if (srch.hit) begin
          mem_we    = 1'b1;
          mem_waddr = AW'(cur_r);
          mem_wdata = mem_rdata | (32'd1 << srch.bit_idx);
          hint_nxt  = cur_r;
          cnt_nxt   = cnt_r - 17'd1;
          res_nxt   = '{status: STAT_OK, granted_block: {cur_r, srch.bit_idx},
                        free_count: cnt_r - 17'd1};
          state_nxt = S_DONE;
        end else if (n_r + 12'd1 == words) begin
          res_nxt   = '{status: STAT_NO_FREE, granted_block: 16'd0, free_count: cnt_r};
          state_nxt = S_DONE;
        end else begin
          cur_nxt = cur_next_idx;
          n_nxt   = n_r + 12'd1;
        end
      end
      S_FREE: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(blk_r[15:5]);
        mem_wdata = mem_rdata & (FULL_WORD ^ (32'd1 << blk_r[4:0]));
        cnt_nxt   = cnt_up;
        if (blk_r[15:5] < hint_r) begin
          hint_nxt = blk_r[15:5];
        end
        res_nxt   = '{status: STAT_OK, granted_block: 16'd0, free_count: cnt_up};
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      hint_r      <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      total_r     <= TOTAL_RST;
      start_r     <= '0;
      init_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      hint_r      <= hint_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_index)
          CFG_TOTAL:     total_r <= cfg_wdata;
          CFG_START:     start_r <= cfg_wdata[15:0];
          CFG_INIT_FREE: init_r  <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    n_r        <= n_nxt;
    blk_r      <= blk_nxt;
    res_r      <= res_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `BNFA_CHECK(a_cnt_bound, cnt_r <= COUNT_MAX, "free counter above maximum")
  `BNFA_CHECK(a_scan_len, (state_r == S_SCAN) |-> (n_r < words), "scan ran past the map")
  `BNFA_CHECK(a_grant_count, (state_r == S_SCAN && srch.hit) |=> (cnt_r == $past(cnt_r) - 17'd1), "grant did not count down")
  `BNFA_CHECK(a_done_emits, (state_r == S_DONE && out_free) |=> (out_valid_r && state_r == S_IDLE), "finished result not presented")

endmodule

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps
// regression bench for bitmap_next_fit_block_allocator: directed and random beats
// checked against an in-bench next-fit predictor; depends on bnfa_pkg and the rtl
module tb_top;
  import bnfa_pkg::*;

  localparam int MAP_DEPTH = 2048;
  localparam int FILL_WORDS = 128;
  localparam int RUN_LIMIT = 3000000;
  localparam int unsigned BLOCK_CAP = 65536;
  localparam logic [1:0] MODE_UNDEF = 2'd3;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  in_beat_t    in_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  out_beat_t   out_data;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [16:0] cfg_wdata = '0;

  bitmap_next_fit_block_allocator #(.MAP_WORDS(MAP_DEPTH)) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  logic [31:0] map_img [MAP_DEPTH];
  int unsigned hint_q = 0;
  int unsigned free_cnt = 0;
  int unsigned total_reg = 65536;
  int unsigned start_reg = 0;
  int unsigned init_reg = 0;
  out_beat_t   due_results [$];
  int unsigned held_blocks [$];
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          recv_hold = 0;
  int          fault_count = 0;
  int          cycle_count = 0;

  initial forever #4 clk = ~clk;

  function automatic int unsigned eff_blocks();
    int unsigned t;
    t = total_reg;
    if (t > BLOCK_CAP) t = BLOCK_CAP;
    if (t > MAP_DEPTH * WORD_BITS) t = MAP_DEPTH * WORD_BITS;
    return t;
  endfunction

  function automatic out_beat_t next_fit_result(input in_beat_t b);
    out_beat_t   r;
    int unsigned total, words, idx, blk, n, k;
    bit          found;
    r = '0;
    total = eff_blocks();
    words = (total + WORD_BITS - 1) / WORD_BITS;
    found = 1'b0;
    case (b.mode)
      MODE_ALLOC: begin
        r.status = STAT_NO_FREE;
        if (free_cnt != 0 && words != 0) begin
          idx = (hint_q < words) ? hint_q : 0;
          for (n = 0; n < words && !found; n++) begin
            if (map_img[idx] != FULL_WORD) begin
              for (k = 0; k < WORD_BITS && !found; k++) begin
                blk = idx * WORD_BITS + k;
                if (!map_img[idx][k] && blk >= start_reg && blk < total) begin
                  map_img[idx][k] = 1'b1;
                  hint_q = idx;
                  free_cnt--;
                  r.status = STAT_OK;
                  r.granted_block = blk[15:0];
                  found = 1'b1;
                  held_blocks.push_back(blk);
                  if (held_blocks.size() > 64) void'(held_blocks.pop_front());
                end
              end
            end
            if (!found) idx = (idx + 1 >= words) ? 0 : idx + 1;
          end
        end
      end
      MODE_FREE: begin
        blk = b.block_number;
        if (blk < start_reg || blk >= total) begin
          r.status = STAT_RANGE;
        end else begin
          map_img[blk / WORD_BITS][blk % WORD_BITS] = 1'b0;
          if (free_cnt < BLOCK_CAP) free_cnt++;
          if (blk / WORD_BITS < hint_q) hint_q = blk / WORD_BITS;
        end
      end
      MODE_LOAD: begin
        map_img[b.word_index] = b.word_value;
        free_cnt = (init_reg > BLOCK_CAP) ? BLOCK_CAP : init_reg;
        hint_q = start_reg / WORD_BITS;
      end
      default: ;
    endcase
    r.free_count = free_cnt[16:0];
    return r;
  endfunction

  function automatic in_beat_t make_beat(input logic [1:0] mode, input int unsigned blk,
                                         input int unsigned widx, input int unsigned wval);
    in_beat_t b;
    b.mode = mode;
    b.block_number = blk[15:0];
    b.word_index = widx[10:0];
    b.word_value = wval;
    return b;
  endfunction

  task automatic send_beat(input in_beat_t b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_data  <= b;
    do @(posedge clk); while (!in_ready);
    due_results.push_back(next_fit_result(b));
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input int unsigned val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    case (idx)
      CFG_TOTAL:     total_reg = val & 32'h1_FFFF;
      CFG_START:     start_reg = val & 32'hFFFF;
      CFG_INIT_FREE: init_reg  = val & 32'h1_FFFF;
      default: ;
    endcase
  endtask

  task automatic apply_setup(input int unsigned total, input int unsigned start,
                             input int unsigned init);
    drain_results();
    write_reg(CFG_TOTAL, total);
    write_reg(CFG_START, start);
    write_reg(CFG_INIT_FREE, init);
  endtask

  task automatic random_setup();
    int unsigned total, lim, start, init;
    case ($urandom_range(3))
      0:       total = $urandom_range(256, 1);
      1:       total = $urandom_range(FILL_WORDS * WORD_BITS, 257);
      2:       total = $urandom_range(FILL_WORDS * WORD_BITS, 1);
      default: total = FILL_WORDS * WORD_BITS;
    endcase
    lim = (total > BLOCK_CAP) ? BLOCK_CAP : total;
    start = ($urandom_range(3) == 0) ? 0 : ($urandom_range(lim - 1) >> $urandom_range(4));
    init = ($urandom_range(3) == 0) ? $urandom_range(131071) : $urandom_range(lim);
    apply_setup(total, start, init);
  endtask

  task automatic run_random(input int count);
    in_beat_t    b;
    int unsigned total, words, roll, rnd, pick;
    for (int i = 0; i < count; i++) begin
      total = eff_blocks();
      words = (total + WORD_BITS - 1) / WORD_BITS;
      roll = (i == 0) ? 85 : $urandom_range(99);
      rnd = $urandom;
      b.block_number = rnd[15:0];
      b.word_index = rnd[26:16];
      b.word_value = $urandom;
      if (roll < 45) begin
        b.mode = MODE_ALLOC;
      end else if (roll < 80) begin
        b.mode = MODE_FREE;
        roll = $urandom_range(9);
        if (roll < 5 && held_blocks.size() != 0) begin
          pick = $urandom_range(held_blocks.size() - 1);
          rnd = held_blocks[pick];
          held_blocks.delete(pick);
          b.block_number = rnd[15:0];
        end else if (roll < 9 && start_reg < total) begin
          rnd = $urandom_range(total - 1, start_reg);
          b.block_number = rnd[15:0];
        end
      end else if (roll < 94) begin
        b.mode = MODE_LOAD;
        if (words != 0 && $urandom_range(3) != 0) begin
          rnd = $urandom_range(words - 1);
          b.word_index = rnd[10:0];
        end
        case ($urandom_range(3))
          0:       b.word_value = FULL_WORD;
          1:       b.word_value = b.word_value & $urandom;
          default: ;
        endcase
      end else begin
        b.mode = MODE_UNDEF;
      end
      send_beat(b);
    end
  endtask

  task automatic test_reset_state();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    send_beat(make_beat(MODE_ALLOC, 0, 0, 0));
    send_beat(make_beat(MODE_UNDEF, 16'hFFFF, 11'h7FF, FULL_WORD));
    drain_results();
  endtask

  task automatic test_map_fill();
    int unsigned val;
    for (int w = 0; w < FILL_WORDS; w++) begin
      case ($urandom_range(7))
        0, 1:    val = FULL_WORD;
        2:       val = 0;
        default: val = $urandom;
      endcase
      send_beat(make_beat(MODE_LOAD, $urandom, w, val));
    end
    drain_results();
  endtask

  task automatic test_directed();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    // oversized total and initial count
    apply_setup(131071, 0, 131071);
    send_beat(make_beat(MODE_LOAD, 0, 0, 0));
    send_beat(make_beat(MODE_LOAD, 0, 2047, FULL_WORD));
    send_beat(make_beat(MODE_ALLOC, 0, 0, 0));
    send_beat(make_beat(MODE_ALLOC, 0, 0, 0));
    send_beat(make_beat(MODE_FREE, 65535, 0, 0));
    send_beat(make_beat(MODE_FREE, 65535, 0, 0));
    send_beat(make_beat(MODE_FREE, 0, 0, 0));
    send_beat(make_beat(MODE_FREE, 0, 0, 0));
    send_beat(make_beat(MODE_UNDEF, 16'hFFFF, 11'h7FF, FULL_WORD));
    // empty data range, hint left past the words in use
    apply_setup(100, 65535, 131071);
    send_beat(make_beat(MODE_LOAD, 0, 3, 0));
    send_beat(make_beat(MODE_ALLOC, 0, 0, 0));
    send_beat(make_beat(MODE_FREE, 50, 0, 0));
    send_beat(make_beat(MODE_FREE, 65535, 0, 0));
    drain_results();
    write_reg(CFG_START, 0);
    send_beat(make_beat(MODE_ALLOC, 0, 0, 0));
    // count nonzero with every bit in use
    apply_setup(64, 0, 65536);
    send_beat(make_beat(MODE_LOAD, 0, 0, FULL_WORD));
    send_beat(make_beat(MODE_LOAD, 0, 1, FULL_WORD));
    send_beat(make_beat(MODE_ALLOC, 0, 0, 0));
    drain_results();
    write_reg(CFG_TOTAL, 0);
    send_beat(make_beat(MODE_ALLOC, 0, 0, 0));
    send_beat(make_beat(MODE_FREE, 0, 0, 0));
    // zero count
    apply_setup(65536, 0, 0);
    send_beat(make_beat(MODE_LOAD, 0, 5, 0));
    send_beat(make_beat(MODE_ALLOC, 0, 0, 0));
    // single block volume
    apply_setup(1, 0, 1);
    send_beat(make_beat(MODE_LOAD, 0, 0, 32'hFFFF_FFFE));
    send_beat(make_beat(MODE_ALLOC, 0, 0, 0));
    send_beat(make_beat(MODE_ALLOC, 0, 0, 0));
    send_beat(make_beat(MODE_FREE, 0, 0, 0));
    send_beat(make_beat(MODE_FREE, 1, 0, 0));
    drain_results();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    random_setup();
    recv_hold = 300;
    run_random(16);
    drain_results();
    run_random(12);
    drain_results();
  endtask

  task automatic test_idle_phases();
    int send_pct [4];
    int recv_pct [4];
    send_pct = '{0, 64, 0, 19};
    recv_pct = '{0, 0, 64, 19};
    for (int p = 0; p < 4; p++) begin
      for (int s = 0; s < 2; s++) begin
        random_setup();
        send_idle_pct = send_pct[p];
        recv_stall_pct = recv_pct[p];
        run_random(80);
      end
    end
    drain_results();
  endtask

  task automatic report_fault(input string what, input out_beat_t want, input out_beat_t got);
    fault_count++;
    if (fault_count <= 10)
      $display("mismatch (%0s): want status %0d block %0d free %0d, got status %0d block %0d free %0d",
               what, want.status, want.granted_block, want.free_count,
               got.status, got.granted_block, got.free_count);
  endtask

  // result checker
  initial begin
    out_beat_t want;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && out_ready) begin
        if (due_results.size() == 0) begin
          report_fault("no result pending", '0, out_data);
        end else begin
          want = due_results.pop_front();
          if (out_data.status !== want.status ||
              out_data.granted_block !== want.granted_block ||
              out_data.free_count !== want.free_count)
            report_fault("field", want, out_data);
        end
      end
    end
  end

  // result side ready, with long hold-off when asked
  initial forever begin
    @(posedge clk);
    if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold--;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_state();
    test_map_fill();
    test_directed();
    test_backpressure();
    test_idle_phases();
    drain_results();
    repeat (8) @(posedge clk);
    if (fault_count == 0 && due_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
+incdir+hdl
hdl/bnfa_pkg.sv
hdl/bnfa_map_ram.sv
hdl/bnfa_word_search.sv
hdl/bitmap_next_fit_block_allocator.sv
tb/tb_top.sv
